/* design/mseg_pkg.sv */
// Shared types and constants for the multi-segment envelope generator.
// No dependencies; imported by the table, divider and top-level modules.
package mseg_pkg;

  localparam int NUM_POINTS_DEF = 8;
  localparam int FRAME_BITS_DEF = 20;

  localparam int LEVEL_W    = 24;
  localparam int VALUE_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int FADE_W     = 12;
  localparam int SP_W       = 4;
  localparam int CMD_W      = 2;
  localparam int PIDX_W     = 3;
  localparam int PFRM_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 2'd2;

  localparam logic [SP_W-1:0]   SP_RST       = 4'hF;
  localparam logic [FADE_W-1:0] FADE_LEN_RST = 12'd48;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [GAIN_W-1:0]  gain;
    logic [PIDX_W-1:0]  point_index;
    logic [PFRM_W-1:0]  point_frames;
    logic [VALUE_W-1:0] point_value;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               done_res;
  } out_item_t;

endpackage

/* design/mseg_table.sv */
// Point table: one synchronous memory of {frames, value} per point.
// One write port, one read port with registered read data. Uses mseg_pkg.
module mseg_table #(
  parameter int NUM_POINTS = mseg_pkg::NUM_POINTS_DEF,
  parameter int FRAME_BITS = mseg_pkg::FRAME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(NUM_POINTS)-1:0] wr_addr,
  input  logic [FRAME_BITS-1:0]        wr_frames,
  input  logic [mseg_pkg::VALUE_W-1:0] wr_value,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_POINTS)-1:0] rd_addr,
  output logic [FRAME_BITS-1:0]        rd_frames,
  output logic [mseg_pkg::VALUE_W-1:0] rd_value
);
  import mseg_pkg::*;

  localparam int ENT_W = FRAME_BITS + VALUE_W;

  logic [ENT_W-1:0] mem [NUM_POINTS];
  logic [ENT_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_frames, wr_value};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_frames = rd_q_r[ENT_W-1:VALUE_W];
  assign rd_value  = rd_q_r[VALUE_W-1:0];

endmodule

/* design/mseg_div.sv */
// Serial restoring divider: unsigned LEVEL_W-bit dividend, one quotient bit per cycle.
// Pulses done in the cycle after the last step. Uses mseg_pkg.
module mseg_div #(
  parameter int DVS_W = mseg_pkg::FRAME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mseg_pkg::LEVEL_W-1:0] dividend,
  input  logic [DVS_W-1:0]             divisor,
  output logic                         done,
  output logic [mseg_pkg::LEVEL_W-1:0] quotient
);
  import mseg_pkg::*;

  localparam int CNT_W = $clog2(LEVEL_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [LEVEL_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [DVS_W:0]     shifted;
  logic [DVS_W:0]     trial;
  logic               fits;

  always_comb begin
    shifted  = {rem_r, quo_r[LEVEL_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    fits     = (shifted >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(LEVEL_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[LEVEL_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/multi_segment_envelope_generator_unit.sv */
// Channel  Handshake              Payload
// in_      in_valid / in_ready    in_data (in_item_t): cmd, gain, point fields
// out_     out_valid / out_ready  out_data (out_item_t): level, done_res
// cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data (sustain, loop, fade length)
//
// Restart, release and table write end in ST_IDLE. A finished tick goes to
// ST_OUT; a held sustain via ST_MUL, ST_CALC; a spent point also via ST_ADV;
// a fade via ST_DIV, a glide via ST_MUL, ST_CALC, ST_DIV, ST_ADV; the 24-step
// serial divider sets their time. One item at a time; ticks stall in ST_OUT
// while the output is full. Sync active-low reset; the table is not cleared.
module multi_segment_envelope_generator_unit #(
  parameter int NUM_POINTS = mseg_pkg::NUM_POINTS_DEF,
  parameter int FRAME_BITS = mseg_pkg::FRAME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mseg_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mseg_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mseg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mseg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mseg_pkg::*;

  localparam int SEG_W = $clog2(NUM_POINTS);
  localparam int CMP_W = (SEG_W + 1 > 5) ? SEG_W + 1 : 5;
  localparam int DVS_W = (FRAME_BITS > FADE_W) ? FRAME_BITS : FADE_W;
  localparam int PROD_W = VALUE_W + GAIN_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_CALC = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_ADV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [SEG_W-1:0]    seg_r, seg_nxt;
  logic [FRAME_BITS-1:0] step_r, step_nxt;
  logic [FADE_W-1:0]   fade_r, fade_nxt;
  logic                sust_r, sust_nxt;
  logic                fin_r, fin_nxt;
  logic                rst_pend_r, rst_pend_nxt;
  logic [SP_W-1:0]     sp_r, sp_nxt;
  logic                loop_r, loop_nxt;
  logic [FADE_W-1:0]   fade_len_r, fade_len_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic                hold_r, hold_nxt;
  logic                oob_r, oob_nxt;
  logic                fade_mode_r, fade_mode_nxt;
  logic                neg_r, neg_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                  in_acc;
  logic                  tbl_wr_en;
  logic [SEG_W-1:0]      tbl_wr_addr;
  logic                  tbl_rd_en;
  logic [SEG_W-1:0]      tbl_rd_addr;
  logic [FRAME_BITS-1:0] tbl_frames;
  logic [VALUE_W-1:0]    tbl_value;

  logic                  div_start;
  logic [LEVEL_W-1:0]    div_dividend;
  logic [DVS_W-1:0]      div_divisor;
  logic                  div_done;
  logic [LEVEL_W-1:0]    div_quo;

  logic                  fin_eff, sust_eff, hold_eff;
  logic [SEG_W-1:0]      seg_eff;
  logic [CMP_W-1:0]      sp_idx, sp_next, seg_inc;
  logic [LEVEL_W-1:0]    target;
  logic [LEVEL_W:0]      diff;
  logic [LEVEL_W:0]      diff_mag;
  logic [FRAME_BITS-1:0] step_inc;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tbl_wr_en   = in_acc && (in_data.cmd == CMD_WRITE) &&
                       (CMP_W'(in_data.point_index) < CMP_W'(NUM_POINTS));
  assign tbl_wr_addr = SEG_W'(in_data.point_index);

  mseg_table #(
    .NUM_POINTS (NUM_POINTS),
    .FRAME_BITS (FRAME_BITS)
  ) u_table (
    .clk       (clk),
    .wr_en     (tbl_wr_en),
    .wr_addr   (tbl_wr_addr),
    .wr_frames (FRAME_BITS'(in_data.point_frames)),
    .wr_value  (in_data.point_value),
    .rd_en     (tbl_rd_en),
    .rd_addr   (tbl_rd_addr),
    .rd_frames (tbl_frames),
    .rd_value  (tbl_value)
  );

  mseg_div #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    seg_nxt       = seg_r;
    step_nxt      = step_r;
    fade_nxt      = fade_r;
    sust_nxt      = sust_r;
    fin_nxt       = fin_r;
    rst_pend_nxt  = rst_pend_r;
    sp_nxt        = sp_r;
    loop_nxt      = loop_r;
    fade_len_nxt  = fade_len_r;
    gain_nxt      = gain_r;
    hold_nxt      = hold_r;
    oob_nxt       = oob_r;
    fade_mode_nxt = fade_mode_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    tbl_rd_en     = 1'b0;
    tbl_rd_addr   = seg_r;
    div_start     = 1'b0;
    div_dividend  = level_r;
    div_divisor   = DVS_W'(fade_r);

    // Effective state after a pending restart, used by a tick
    fin_eff  = rst_pend_r ? 1'b0 : fin_r;
    sust_eff = rst_pend_r ? 1'b0 : sust_r;
    seg_eff  = rst_pend_r ? '0 : seg_r;
    hold_eff = sust_eff && !sp_r[SP_W-1];
    sp_idx   = CMP_W'(sp_r[SP_W-2:0]);
    sp_next  = sp_idx + 1'b1;
    seg_inc  = CMP_W'(seg_r) + 1'b1;
    step_inc = step_r + 1'b1;
    target   = oob_r ? '0 : prod_r[PROD_W-1:PROD_W-LEVEL_W];
    diff     = {1'b0, target} - {1'b0, level_r};
    diff_mag = diff[LEVEL_W] ? ({(LEVEL_W + 1){1'b0}} - diff) : diff;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SUSTAIN: sp_nxt = cfg_data[SP_W-1:0];
        CFG_LOOP:    loop_nxt = cfg_data[0];
        CFG_FADE:    fade_len_nxt = cfg_data[FADE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.cmd)
            CMD_RESTART: begin
              sust_nxt     = 1'b0;
              fin_nxt      = 1'b0;
              seg_nxt      = '0;
              step_nxt     = '0;
              fade_nxt     = '0;
              rst_pend_nxt = 1'b0;
            end
            CMD_RELEASE: begin
              if (!sp_r[SP_W-1]) begin
                sust_nxt = 1'b0;
                step_nxt = '0;
                if (sp_next >= CMP_W'(NUM_POINTS)) begin
                  fin_nxt = 1'b1;
                  seg_nxt = '0;
                end else begin
                  seg_nxt = sp_next[SEG_W-1:0];
                end
              end else if (fade_len_r != '0) begin
                fade_nxt = fade_len_r;
              end
            end
            CMD_TICK: begin
              gain_nxt = in_data.gain;
              if (fade_r != '0) begin
                div_start     = 1'b1;
                fade_mode_nxt = 1'b1;
                state_nxt     = ST_DIV;
              end else begin
                fade_mode_nxt = 1'b0;
                if (rst_pend_r) begin
                  sust_nxt     = 1'b0;
                  fin_nxt      = 1'b0;
                  seg_nxt      = '0;
                  step_nxt     = '0;
                  rst_pend_nxt = 1'b0;
                end
                if (fin_eff) begin
                  level_nxt = '0;
                  state_nxt = ST_OUT;
                end else begin
                  tbl_rd_en   = 1'b1;
                  tbl_rd_addr = hold_eff ? SEG_W'(sp_r[SP_W-2:0]) : seg_eff;
                  hold_nxt    = hold_eff;
                  oob_nxt     = hold_eff && (sp_idx >= CMP_W'(NUM_POINTS));
                  state_nxt   = ST_MUL;
                end
              end
            end
            default: ;  // table write goes straight to the memory port
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt  = tbl_value * gain_r;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (hold_r) begin
          level_nxt = target;
          state_nxt = ST_OUT;
        end else if (tbl_frames > step_r) begin
          div_start    = 1'b1;
          div_dividend = diff_mag[LEVEL_W-1:0];
          div_divisor  = DVS_W'(tbl_frames - step_r);
          neg_nxt      = diff[LEVEL_W];
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (fade_mode_r) begin
            level_nxt = level_r - div_quo;
            fade_nxt  = fade_r - 1'b1;
            if (fade_r == FADE_W'(1)) begin
              fin_nxt = 1'b1;
            end
            state_nxt = ST_OUT;
          end else begin
            level_nxt = neg_r ? (level_r - div_quo) : (level_r + div_quo);
            state_nxt = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        // Advance the point once its frames are used up, or enter sustain at the sustain point
        if ((step_inc >= tbl_frames) && !sust_r) begin
          step_nxt = '0;
          if (!sp_r[SP_W-1] && (CMP_W'(seg_r) == sp_idx)) begin
            sust_nxt = 1'b1;
          end else if (seg_inc >= CMP_W'(NUM_POINTS)) begin
            seg_nxt = '0;
            if (!loop_r) begin
              fin_nxt = 1'b1;
            end
          end else begin
            seg_nxt = seg_inc[SEG_W-1:0];
          end
        end else begin
          step_nxt = step_inc;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.level    = level_r;
          out_data_nxt.done_res = fin_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      seg_r       <= '0;
      step_r      <= '0;
      fade_r      <= '0;
      sust_r      <= 1'b0;
      fin_r       <= 1'b1;
      rst_pend_r  <= 1'b1;
      sp_r        <= SP_RST;
      loop_r      <= 1'b0;
      fade_len_r  <= FADE_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      seg_r       <= seg_nxt;
      step_r      <= step_nxt;
      fade_r      <= fade_nxt;
      sust_r      <= sust_nxt;
      fin_r       <= fin_nxt;
      rst_pend_r  <= rst_pend_nxt;
      sp_r        <= sp_nxt;
      loop_r      <= loop_nxt;
      fade_len_r  <= fade_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    gain_r      <= gain_nxt;
    hold_r      <= hold_nxt;
    oob_r       <= oob_nxt;
    fade_mode_r <= fade_mode_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
